// File: sv/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, codes and helpers of the integer matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 32;
    localparam int CFG_AW      = 4;
    localparam int CFG_DW      = 32;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_MUL    = 2'd2;

    localparam logic [1:0] REG_ROWS_A  = 2'd0;
    localparam logic [1:0] REG_INNER_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B  = 2'd2;
    localparam logic [1:0] REG_COLS_B  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] product;
        logic                    last;
        logic                    mismatch;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] inner_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
    } t_dims;

    typedef struct packed {
        logic issue;
        logic first;
    } t_mac_ctl;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int max_dim);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > max_dim) begin
            res = DIM_W'(max_dim);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/int_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// int_matrix_multiply_core
// Integer matrix multiply engine with APB configuration of matrix sizes.
// ----------------------------------------------------------------------------
// A load item (op 0 for A, op 1 for B) is written to its store. A compute item
// (op 2) holds the input stalled while one multiply-accumulate unit walks the
// product in row-major order: each element takes one MAC step per inner index,
// then drains the store read, product and accumulate registers, then is handed
// to the output register, which output stall can hold. A size mismatch gives
// its single item straight to the output register. Store entries must be
// loaded before a compute reads them.
`default_nettype none

module int_matrix_multiply_core #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire imm_pkg::t_in_item           i_in_item,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output imm_pkg::t_out_item               o_out_item,
    input  wire logic                        i_out_stall,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [imm_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [imm_pkg::CFG_DW-1:0]  pwdata,
    output logic [imm_pkg::CFG_DW-1:0]       prdata,
    output logic                             pready
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

    imm_pkg::t_dims                r_dims;
    logic                          cfg_wr;
    logic [1:0]                    cfg_idx;
    logic [imm_pkg::DIM_W-1:0]     cfg_val;
    logic [imm_pkg::DIM_W-1:0]     rd_val;
    logic                          we_a;
    logic                          we_b;
    logic [AW-1:0]                 waddr;
    logic [imm_pkg::VAL_W-1:0]     wdata;
    logic [AW-1:0]                 raddr_a;
    logic [AW-1:0]                 raddr_b;
    logic [imm_pkg::VAL_W-1:0]     rdata_a;
    logic [imm_pkg::VAL_W-1:0]     rdata_b;
    imm_pkg::t_mac_ctl             mac_ctl;
    logic                          mac_busy;
    logic [imm_pkg::VAL_W-1:0]     acc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];
    assign cfg_val = imm_pkg::clamp_dim(pwdata[imm_pkg::DIM_W-1:0], MAX_DIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.rows_a  <= imm_pkg::clamp_dim(imm_pkg::DIM_W'(8), MAX_DIM);
            r_dims.inner_a <= imm_pkg::clamp_dim(imm_pkg::DIM_W'(8), MAX_DIM);
            r_dims.rows_b  <= imm_pkg::clamp_dim(imm_pkg::DIM_W'(8), MAX_DIM);
            r_dims.cols_b  <= imm_pkg::clamp_dim(imm_pkg::DIM_W'(8), MAX_DIM);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                imm_pkg::REG_ROWS_A:  r_dims.rows_a  <= cfg_val;
                imm_pkg::REG_INNER_A: r_dims.inner_a <= cfg_val;
                imm_pkg::REG_ROWS_B:  r_dims.rows_b  <= cfg_val;
                imm_pkg::REG_COLS_B:  r_dims.cols_b  <= cfg_val;
                default:              r_dims         <= r_dims;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            imm_pkg::REG_ROWS_A:  rd_val = r_dims.rows_a;
            imm_pkg::REG_INNER_A: rd_val = r_dims.inner_a;
            imm_pkg::REG_ROWS_B:  rd_val = r_dims.rows_b;
            imm_pkg::REG_COLS_B:  rd_val = r_dims.cols_b;
            default:              rd_val = '0;
        endcase
    end

    assign prdata = imm_pkg::CFG_DW'(rd_val);

    imm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_dims      (r_dims),
        .o_we_a      (we_a),
        .o_we_b      (we_b),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_mac       (mac_ctl),
        .i_mac_busy  (mac_busy),
        .i_acc       (acc),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    imm_ram #(
        .WIDTH (imm_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_left_store (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    imm_ram #(
        .WIDTH (imm_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_right_store (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    imm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_busy  (mac_busy),
        .o_acc   (acc)
    );

endmodule

`default_nettype wire

// File: sv/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac
// Shared multiply-accumulate unit: registered product, then wrapping sum.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire imm_pkg::t_mac_ctl           i_ctl,
    input  wire logic [imm_pkg::VAL_W-1:0]   i_a,
    input  wire logic [imm_pkg::VAL_W-1:0]   i_b,
    output logic                             o_busy,
    output logic [imm_pkg::VAL_W-1:0]        o_acc
);

    logic                          r_v1;
    logic                          r_f1;
    logic                          r_v2;
    logic                          r_f2;
    logic [imm_pkg::VAL_W-1:0]     r_prod;
    logic [imm_pkg::VAL_W-1:0]     r_acc;
    logic [imm_pkg::VAL_W-1:0]     n_full;

    assign n_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
        r_f1 <= i_ctl.first;
        r_f2 <= r_f1;
        if (r_v1) begin
            r_prod <= n_full;
        end
        if (r_v2) begin
            r_acc <= r_f2 ? r_prod : r_acc + r_prod;
        end
    end

    assign o_busy = r_v1 | r_v2;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

// File: sv/imm_seq.sv
// ----------------------------------------------------------------------------
// imm_seq
// Sequencer: takes items, writes the stores, walks the product elements
// through the shared MAC and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_seq #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire imm_pkg::t_in_item         i_in_item,
    output logic                           o_in_stall,
    input  wire imm_pkg::t_dims            i_dims,
    output logic                           o_we_a,
    output logic                           o_we_b,
    output logic [AW-1:0]                  o_waddr,
    output logic [imm_pkg::VAL_W-1:0]      o_wdata,
    output logic [AW-1:0]                  o_raddr_a,
    output logic [AW-1:0]                  o_raddr_b,
    output imm_pkg::t_mac_ctl              o_mac,
    input  wire logic                      i_mac_busy,
    input  wire logic [imm_pkg::VAL_W-1:0] i_acc,
    output logic                           o_out_valid,
    output imm_pkg::t_out_item             o_out_item,
    input  wire logic                      i_out_stall
);

    imm_pkg::t_state            r_state;
    imm_pkg::t_state            n_state;
    logic [imm_pkg::DIM_W-1:0]  r_i;
    logic [imm_pkg::DIM_W-1:0]  r_j;
    logic [imm_pkg::DIM_W-1:0]  r_k;
    logic [imm_pkg::DIM_W-1:0]  n_i;
    logic [imm_pkg::DIM_W-1:0]  n_j;
    logic [imm_pkg::DIM_W-1:0]  n_k;
    logic                       r_mis;
    logic                       n_mis;
    logic                       r_out_valid;
    imm_pkg::t_out_item         r_out_item;
    logic                       accept;
    logic                       is_mul;
    logic                       dim_bad;
    logic                       k_last;
    logic                       j_last;
    logic                       i_last;
    logic                       run_last;
    logic                       out_load;
    logic                       load_ok;

    assign accept   = i_in_valid && !o_in_stall;
    assign is_mul   = i_in_item.op == imm_pkg::OP_MUL;
    assign dim_bad  = i_dims.inner_a != i_dims.rows_b;
    assign k_last   = r_k == i_dims.inner_a - imm_pkg::DIM_W'(1);
    assign j_last   = r_j == i_dims.cols_b - imm_pkg::DIM_W'(1);
    assign i_last   = r_i == i_dims.rows_a - imm_pkg::DIM_W'(1);
    assign run_last = r_mis || (i_last && j_last);
    assign load_ok  = (int'(i_in_item.row) < MAX_DIM) && (int'(i_in_item.col) < MAX_DIM);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imm_pkg::ST_IDLE: begin
                if (accept && is_mul) begin
                    n_state = dim_bad ? imm_pkg::ST_EMIT : imm_pkg::ST_MAC;
                end
            end
            imm_pkg::ST_MAC: begin
                if (k_last) begin
                    n_state = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN: begin
                if (!i_mac_busy) begin
                    n_state = imm_pkg::ST_EMIT;
                end
            end
            imm_pkg::ST_EMIT: begin
                if (out_load) begin
                    n_state = run_last ? imm_pkg::ST_IDLE : imm_pkg::ST_MAC;
                end
            end
            default: n_state = imm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_mac      = '0;
        out_load   = 1'b0;
        unique case (r_state)
            imm_pkg::ST_IDLE:  o_in_stall = 1'b0;
            imm_pkg::ST_MAC: begin
                o_mac.issue = 1'b1;
                o_mac.first = r_k == '0;
            end
            imm_pkg::ST_DRAIN: o_mac = '0;
            imm_pkg::ST_EMIT:  out_load = !r_out_valid || !i_out_stall;
            default:           o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        o_we_a = 1'b0;
        o_we_b = 1'b0;
        if (accept && load_ok) begin
            unique case (i_in_item.op)
                imm_pkg::OP_LOAD_A: o_we_a = 1'b1;
                imm_pkg::OP_LOAD_B: o_we_b = 1'b1;
                default:            o_we_a = 1'b0;
            endcase
        end
    end

    assign o_waddr   = AW'(int'(i_in_item.row) * MAX_DIM + int'(i_in_item.col));
    assign o_wdata   = i_in_item.value;
    assign o_raddr_a = AW'(int'(r_i) * MAX_DIM + int'(r_k));
    assign o_raddr_b = AW'(int'(r_k) * MAX_DIM + int'(r_j));

    always_comb begin
        n_i   = r_i;
        n_j   = r_j;
        n_k   = r_k;
        n_mis = r_mis;
        if (r_state == imm_pkg::ST_IDLE && accept && is_mul) begin
            n_i   = '0;
            n_j   = '0;
            n_k   = '0;
            n_mis = dim_bad;
        end else if (r_state == imm_pkg::ST_MAC) begin
            n_k = k_last ? '0 : r_k + imm_pkg::DIM_W'(1);
        end else if (r_state == imm_pkg::ST_EMIT && out_load && !run_last) begin
            if (j_last) begin
                n_j = '0;
                n_i = r_i + imm_pkg::DIM_W'(1);
            end else begin
                n_j = r_j + imm_pkg::DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_mis <= n_mis;
        if (out_load) begin
            r_out_item.out_row  <= r_i[imm_pkg::IDX_W-1:0];
            r_out_item.out_col  <= r_j[imm_pkg::IDX_W-1:0];
            r_out_item.product  <= r_mis ? '0 : i_acc;
            r_out_item.last     <= run_last;
            r_out_item.mismatch <= r_mis;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_mis_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.mismatch) |->
            (r_out_item.last && r_out_item.product == '0))
        else $error("mismatch item without last or with nonzero product");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imm_pkg::ST_EMIT && !r_mis) |-> !i_mac_busy)
        else $error("result taken while MAC still busy");

    a_drain_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imm_pkg::ST_DRAIN) |=>
            (r_state == imm_pkg::ST_DRAIN || r_state == imm_pkg::ST_EMIT))
        else $error("drain left for a state other than emit");

    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imm_pkg::ST_IDLE) |=> (!i_mac_busy || $past(i_mac_busy)))
        else $error("MAC started while sequencer idle");
`endif

endmodule

`default_nettype wire
